>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the dispatcher RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define TQDT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TQDT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> rtl/tqdt_pkg.sv
// ---------------------------------------------------------------------------
// tqdt_pkg
// Types and constants shared by the task dispatcher modules.
// ---------------------------------------------------------------------------
package tqdt_pkg;

    localparam int ID_W    = 8;
    localparam int DELAY_W = 32;
    localparam int CNT_W   = 5;

    localparam logic [ID_W-1:0]  ID_IDLE   = 8'd0;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        FUNC_POST     = 2'd0,
        FUNC_SCHEDULE = 2'd1,
        FUNC_DISPATCH = 2'd2,
        FUNC_TICK     = 2'd3
    } t_func;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_REWRITTEN = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // One timer slot.
    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [DELAY_W-1:0] rem;
    } t_entry;

    // Ready queue status toward the control.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

>>> rtl/tqdt_cell.sv
// ---------------------------------------------------------------------------
// tqdt_cell
// One timer slot of the rotating timer chain.
// ---------------------------------------------------------------------------
module tqdt_cell
    import tqdt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    logic [ID_W-1:0]    r_task;
    logic [DELAY_W-1:0] r_rem;

    // slot id resets to free; delay is only looked at when the slot is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task <= ID_IDLE;
        end else if (i_shift) begin
            r_task <= i_entry.task_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rem <= i_entry.rem;
        end
    end

    assign o_entry = '{task_id: r_task, rem: r_rem};

endmodule

>>> rtl/tqdt_ready_fifo.sv
// ---------------------------------------------------------------------------
// tqdt_ready_fifo
// Ready queue: circular buffer memory with head, tail and fill count.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tqdt_ready_fifo
    import tqdt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [ID_W-1:0] i_push_data,
    input  logic            i_pop,
    output logic [ID_W-1:0] o_head_data,
    output t_fifo_stat      o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;
    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_tail, n_tail;
    logic [FW-1:0]   r_fill, n_fill;
    logic            w_full, w_empty, w_push_ok, w_pop_ok;

    assign w_full    = (r_fill == FW'(DEPTH));
    assign w_empty   = (r_fill == '0);
    assign w_push_ok = i_push && !w_full;
    assign w_pop_ok  = i_pop && !w_empty;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (w_push_ok) begin
            n_tail = (r_tail == PW'(DEPTH - 1)) ? '0 : PW'(r_tail + 1'b1);
        end
        if (w_pop_ok) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : PW'(r_head + 1'b1);
        end
        if (w_push_ok && !w_pop_ok) begin
            n_fill = FW'(r_fill + 1'b1);
        end else if (w_pop_ok && !w_push_ok) begin
            n_fill = FW'(r_fill - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // storage, registered read of the current head
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    assign o_head_data = r_rd_data;
    assign o_stat      = '{full: w_full, empty: w_empty};

    `TQDT_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill <= FW'(DEPTH))
    `TQDT_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_fill != '0) || (r_head == r_tail))
    `TQDT_ASSERT_NEXT(a_push_fill, i_clk, i_rst_n, w_push_ok && !w_pop_ok,
        r_fill == FW'($past(r_fill) + 1'b1))

endmodule

>>> rtl/task_queue_with_delay_timers_core.sv
// ---------------------------------------------------------------------------
// task_queue_with_delay_timers_core
// Cooperative task dispatcher: ready FIFO plus a rotating chain of timers.
// ---------------------------------------------------------------------------
// One request is worked at a time and always gives one result transfer.
// Post and dispatch pass through accept, queue access and result. A tick
// takes one full turn of the timer chain; a schedule takes one turn looking
// for an existing timer and, if none is found, a second turn filling the
// first free slot. The timer slots sit in a chain of cells that rotates by
// one slot per cycle past a single update point. A post or schedule with
// task id 0 goes from accept straight to the result. A new request is taken
// while the previous result still waits in the output register. No
// clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module task_queue_with_delay_timers_core
    import tqdt_pkg::*;
#(
    parameter int QUEUE_SLOTS = 16,
    parameter int TIMER_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [ID_W-1:0]    i_task_id,
    input  logic [DELAY_W-1:0] i_delay,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [ID_W-1:0]    o_next_task,
    output logic [1:0]         o_status,
    output logic [CNT_W-1:0]   o_fired_count,
    output logic [CNT_W-1:0]   o_lost_count
);

    // rotation counter, one count per slot
    localparam int CW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_POST    = 7'b0000010,
        S_DISP    = 7'b0000100,
        S_SCHED_A = 7'b0001000,   // turn looking for an existing timer
        S_SCHED_B = 7'b0010000,   // turn filling the first free slot
        S_TICK    = 7'b0100000,
        S_FINISH  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_id, n_id;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic [ID_W-1:0]    r_next, n_next;
    logic [1:0]         r_status, n_status;
    logic [CNT_W-1:0]   r_fired, n_fired;
    logic [CNT_W-1:0]   r_lost, n_lost;

    // output register
    logic               r_o_valid;
    logic [ID_W-1:0]    r_o_next;
    logic [1:0]         r_o_status;
    logic [CNT_W-1:0]   r_o_fired;
    logic [CNT_W-1:0]   r_o_lost;

    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_shift;
    logic               w_last;
    logic               w_push;
    logic [ID_W-1:0]    w_push_data;
    logic               w_pop;
    logic [ID_W-1:0]    w_head_data;
    t_fifo_stat         w_fifo;

    // timer chain: slot 0 sits at the update point, updated entry re-enters
    // at the far end, so after one full turn every slot is back in place
    t_entry             w_cell [TIMER_SLOTS];
    t_entry             w_head;
    t_entry             w_proc;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_shift    = (r_state == S_SCHED_A) || (r_state == S_SCHED_B)
                        || (r_state == S_TICK);
    assign w_last     = (r_cnt == CW'(TIMER_SLOTS - 1));
    assign w_head     = w_cell[0];

    always_comb begin
        n_state     = r_state;
        n_id        = r_id;
        n_delay     = r_delay;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_next      = r_next;
        n_status    = r_status;
        n_fired     = r_fired;
        n_lost      = r_lost;
        w_push      = 1'b0;
        w_push_data = r_id;
        w_pop       = 1'b0;
        w_out_load  = 1'b0;
        w_proc      = w_head;

        if (w_shift) begin
            n_cnt = w_last ? '0 : CW'(r_cnt + 1'b1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id     = i_task_id;
                    n_delay  = i_delay;
                    n_cnt    = '0;
                    n_hit    = 1'b0;
                    n_next   = ID_IDLE;
                    n_status = ST_DONE;
                    n_fired  = '0;
                    n_lost   = '0;
                    unique case (t_func'(i_func))
                        FUNC_POST:
                            n_state = (i_task_id == ID_IDLE) ? S_FINISH : S_POST;
                        FUNC_SCHEDULE:
                            n_state = (i_task_id == ID_IDLE) ? S_FINISH : S_SCHED_A;
                        FUNC_DISPATCH:
                            n_state = S_DISP;
                        FUNC_TICK:
                            n_state = S_TICK;
                    endcase
                end
            end
            S_POST: begin
                if (w_fifo.full) begin
                    n_status = ST_FULL;
                end else begin
                    w_push = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_DISP: begin
                // head data was read at the transfer edge
                if (!w_fifo.empty) begin
                    n_next = w_head_data;
                    w_pop  = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_SCHED_A: begin
                // ids in the table are unique, so at most one slot matches
                if (w_head.task_id == r_id) begin
                    w_proc.rem = r_delay;
                    n_hit      = 1'b1;
                end
                if (w_last) begin
                    if (n_hit) begin
                        n_status = ST_REWRITTEN;
                        n_state  = S_FINISH;
                    end else begin
                        n_state  = S_SCHED_B;
                    end
                end
            end
            S_SCHED_B: begin
                if (!r_hit && (w_head.task_id == ID_IDLE)) begin
                    w_proc.task_id = r_id;
                    w_proc.rem     = r_delay;
                    n_hit          = 1'b1;
                end
                if (w_last) begin
                    n_status = n_hit ? ST_DONE : ST_FULL;
                    n_state  = S_FINISH;
                end
            end
            S_TICK: begin
                if (w_head.task_id != ID_IDLE) begin
                    if (w_head.rem > 32'd1) begin
                        w_proc.rem = w_head.rem - 32'd1;
                    end else begin
                        // expired: slot is freed whether or not it fits
                        w_proc.task_id = ID_IDLE;
                        w_push_data    = w_head.task_id;
                        if (!w_fifo.full) begin
                            w_push = 1'b1;
                            if (r_fired != COUNT_MAX) begin
                                n_fired = CNT_W'(r_fired + 1'b1);
                            end
                        end else if (r_lost != COUNT_MAX) begin
                            n_lost = CNT_W'(r_lost + 1'b1);
                        end
                    end
                end
                if (w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_delay  <= n_delay;
        r_next   <= n_next;
        r_status <= n_status;
        r_fired  <= n_fired;
        r_lost   <= n_lost;
    end

    // result register: a new result loads only when the old one has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_next   <= r_next;
            r_o_status <= r_status;
            r_o_fired  <= r_fired;
            r_o_lost   <= r_lost;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_next_task   = r_o_next;
    assign o_status      = r_o_status;
    assign o_fired_count = r_o_fired;
    assign o_lost_count  = r_o_lost;

    // timer cell chain
    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        t_entry w_in;
        if (g == TIMER_SLOTS - 1) begin : g_tail
            assign w_in = w_proc;
        end else begin : g_mid
            assign w_in = w_cell[g + 1];
        end
        tqdt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_in),
            .o_entry (w_cell[g])
        );
    end

    tqdt_ready_fifo #(
        .DEPTH (QUEUE_SLOTS)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head_data (w_head_data),
        .o_stat      (w_fifo)
    );

    `TQDT_ASSERT(a_cnt_idle, i_clk, i_rst_n, w_shift || (r_cnt == '0))
    `TQDT_ASSERT(a_no_push_full, i_clk, i_rst_n, !w_push || !w_fifo.full)
    `TQDT_ASSERT(a_tick_result, i_clk, i_rst_n,
        !(o_valid && ((o_fired_count != '0) || (o_lost_count != '0)))
        || ((o_next_task == ID_IDLE) && (o_status == ST_DONE)))

endmodule
